// ===== rtl/jse_pkg.sv =====
package jse_pkg;

  localparam int unsigned LenW = 3;

  localparam logic [7:0] CtrlLimit = 8'h20;

  localparam logic [LenW-1:0] PlainLen   = 3'd1;
  localparam logic [LenW-1:0] ShortLen   = 3'd2;
  localparam logic [LenW-1:0] UnicodeLen = 3'd6;

  // Byte emitted at one position of an output piece (plain or escape), with the piece length
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [7:0]      ch;
  } piece_t;

endpackage

// ===== rtl/json_string_escape_encoder.sv =====
// Channel | Handshake                  | Payload
// --------+----------------------------+----------------------------------------
// in      | in_valid_i / in_ready_o    | in_byte_i
// out     | out_valid_o / out_ready_i  | out_byte_o, run_last_o, string_done_o,
//         |                            | out_length_o
// cfg     | cfg_we_i (no wait)         | cfg_wdata_i (output_capacity)
//
// A plain byte or a terminator gives one output byte; an escape (2 or 6
// output bytes) holds its input register, one output byte per cycle from the
// escape sequencer while the output does not stall. A dropped byte (halted,
// or piece does not fit) leaves with no transfer. A result passes the input
// register, then the output register. Output stalls hold the output register
// and back up into the input register. Reset clears the count, the halt flag
// and sets the capacity to 256.
module json_string_escape_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        string_done_o,
  output logic [15:0] out_length_o
);

  logic [15:0] cap_q;
  logic [15:0] count_q;
  logic        halted_q;

  logic        item_vld_q;
  logic [7:0]  item_q;
  logic [jse_pkg::LenW-1:0] idx_q;

  logic        out_vld_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_done_q;
  logic [15:0] out_len_q;

  jse_pkg::piece_t piece;

  logic        out_load;
  logic        term;
  logic        fits;
  logic        drop;
  logic        emit;
  logic        last;
  logic        item_done;
  logic [16:0] need;

  jse_classify u_classify (
    .byte_i (item_q),
    .idx_i  (idx_q),
    .piece_o(piece)
  );

  assign out_load = !out_vld_q || out_ready_i;
  assign term     = (item_q == 8'd0);
  assign need     = {1'b0, count_q} + {14'd0, piece.len};
  assign fits     = need < {1'b0, cap_q};
  // fit check only at the start of a piece
  assign drop     = item_vld_q && !term && (idx_q == '0) && (halted_q || !fits);
  assign emit     = item_vld_q && out_load && !drop;
  assign last     = term || (idx_q == piece.len - jse_pkg::LenW'(1));
  assign item_done = drop || (emit && last);
  assign in_ready_o = !item_vld_q || item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= 16'd256;
      count_q    <= '0;
      halted_q   <= 1'b0;
      item_vld_q <= 1'b0;
      idx_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end

      if (in_valid_i && in_ready_o) begin
        item_vld_q <= 1'b1;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
      end

      if (item_done) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= idx_q + jse_pkg::LenW'(1);
      end

      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      if (emit && term) begin
        count_q  <= '0;
        halted_q <= 1'b0;
      end else if (emit) begin
        count_q <= count_q + 16'd1;
      end else if (drop) begin
        halted_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_byte_i;
    end
    if (emit) begin
      out_last_q <= last;
      out_done_q <= term;
      if (term) begin
        out_byte_q <= 8'd0;
        out_len_q  <= count_q;
      end else begin
        out_byte_q <= piece.ch;
        out_len_q  <= count_q + 16'd1;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = out_last_q;
  assign string_done_o = out_done_q;
  assign out_length_o  = out_len_q;

endmodule

// ===== rtl/jse_classify.sv =====
module jse_classify (
  input  logic [7:0]               byte_i,
  input  logic [jse_pkg::LenW-1:0] idx_i,
  output jse_pkg::piece_t          piece_o
);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChU = 8'h75;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = ChZero + {4'd0, v};
    end else begin
      r = ChLowerA + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  logic [7:0] letter;
  logic       short_esc;

  always_comb begin
    short_esc = 1'b1;
    letter    = byte_i;
    unique case (byte_i)
      ChQuote:  letter = ChQuote;
      ChBslash: letter = ChBslash;
      8'h08:    letter = 8'h62; // b
      8'h0c:    letter = 8'h66; // f
      8'h0a:    letter = 8'h6e; // n
      8'h0d:    letter = 8'h72; // r
      8'h09:    letter = 8'h74; // t
      default:  short_esc = 1'b0;
    endcase
  end

  always_comb begin
    piece_o.len = jse_pkg::PlainLen;
    piece_o.ch  = byte_i;
    if (short_esc) begin
      piece_o.len = jse_pkg::ShortLen;
      piece_o.ch  = (idx_i == '0) ? ChBslash : letter;
    end else if (byte_i < jse_pkg::CtrlLimit) begin
      // \u00XX with lower-case hex digits
      piece_o.len = jse_pkg::UnicodeLen;
      unique case (idx_i)
        3'd0:    piece_o.ch = ChBslash;
        3'd1:    piece_o.ch = ChU;
        3'd4:    piece_o.ch = ChZero + {7'd0, byte_i[4]};
        3'd5:    piece_o.ch = hex_digit(byte_i[3:0]);
        default: piece_o.ch = ChZero;
      endcase
    end
  end

endmodule
